[sv/pid_controller_clamped_defines.svh]
// Assertion macros shared by the PID controller RTL.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define PCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pid_controller_clamped: assertion failed");

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pid_controller_clamped: assertion failed");

`endif

[sv/pcc_pkg.sv]
// Types, widths and register codes shared by the PID controller files.
package pcc_pkg;

  localparam int unsigned SCALE_SHIFT = 8;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ERR_W  = DATA_W + 1;
  localparam int unsigned PROD_W = DATA_W + ERR_W;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned TOT_W  = SUM_W + 1;

  localparam logic [TOT_W-1:0] ROUND_MASK = TOT_W'((64'd1 << SCALE_SHIFT) - 64'd1);

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_SETPOINT = 3'd3,
    REG_MIN_OUT  = 3'd4,
    REG_MAX_OUT  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    data_t gain_p;
    data_t gain_i;
    data_t gain_d;
    data_t setpoint;
    data_t min_out;
    data_t max_out;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:   16'sh0000,
    gain_i:   16'sh0000,
    gain_d:   16'sh0000,
    setpoint: 16'sh0000,
    min_out:  16'sh8000,
    max_out:  16'sh7fff
  };

endpackage

[sv/pcc_if.sv]
// Valid/ready channel interfaces for the PID controller ports.
interface pcc_meas_if import pcc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface pcc_drive_if import pcc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

interface pcc_cfg_if import pcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  data_t            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/pcc_cfg_regs.sv]
// Configuration register file of the PID controller.
module pcc_cfg_regs import pcc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pcc_cfg_if.sink cfg_i,
  output cfg_t   cfg_o
);

  cfg_t cfg_q;

  // Writes never stall; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_GAIN_P:   cfg_q.gain_p   <= cfg_i.data;
        REG_GAIN_I:   cfg_q.gain_i   <= cfg_i.data;
        REG_GAIN_D:   cfg_q.gain_d   <= cfg_i.data;
        REG_SETPOINT: cfg_q.setpoint <= cfg_i.data;
        REG_MIN_OUT:  cfg_q.min_out  <= cfg_i.data;
        REG_MAX_OUT:  cfg_q.max_out  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/pid_controller_clamped.sv]
// Top level of the clamped PID controller with derivative on measurement.
//
// Each measurement request produces exactly one drive request. The block forms
// error = setpoint - measurement, adds gain_i * error to a 32-bit integral that is
// clamped to the output limits scaled by 2^SCALE_SHIFT, and then computes
// gain_p * error + integral - gain_d * (measurement - previous measurement) at full
// width. That sum is divided by 2^SCALE_SHIFT rounding toward zero and clamped to
// [min_out, max_out]. When min_out is above max_out the lower limit wins for both
// the integral and the drive. The datapath is a four-stage pipeline (input
// register, product register, integral register, output register), which a
// measurement passes in that order, and one measurement can be accepted every
// cycle while the drive channel does not stall. The one-per-cycle figure is set
// by the integral add-and-clamp feedback loop in the third stage. Each stage
// holds its item while the stage after it is full, so bubbles are squeezed out
// and new measurements are still taken while a drive request waits, until every
// stage is full. Configuration registers are written through their own channel,
// which never stalls; they must only change while no measurement is in flight.
`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped import pcc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcc_cfg_if.sink       cfg_i,
  pcc_meas_if.sink      meas_i,
  pcc_drive_if.source   drive_o
);

  cfg_t cfg;

  pcc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Pipeline registers.
  logic                     s0_valid_q;
  data_t                    s0_meas_q;
  data_t                    prev_meas_q;
  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] s1_prod_p_q;
  logic signed [PROD_W-1:0] s1_prod_i_q;
  logic signed [PROD_W-1:0] s1_prod_d_q;
  logic                     s2_valid_q;
  logic signed [SUM_W-1:0]  s2_pd_q;
  logic signed [ACC_W-1:0]  integral_q;
  logic                     out_valid_q;
  data_t                    out_drive_q;

  // Handshake: a stage is free when empty or when its item moves on this cycle.
  logic out_free, s2_free, s1_free, s0_free;
  logic s0_load, s1_load, s2_load, out_load;

  assign out_free = !out_valid_q || drive_o.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s0_free  = !s0_valid_q || s1_free;

  assign s0_load  = meas_i.valid && s0_free;
  assign s1_load  = s0_valid_q && s1_free;
  assign s2_load  = s1_valid_q && s2_free;
  assign out_load = s2_valid_q && out_free;

  assign meas_i.ready  = s0_free;
  assign drive_o.valid = out_valid_q;
  assign drive_o.drive = out_drive_q;

  // Stage 1: error, measurement step and the three gain products.
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  diff;
  logic signed [PROD_W-1:0] prod_p_d;
  logic signed [PROD_W-1:0] prod_i_d;
  logic signed [PROD_W-1:0] prod_d_d;

  always_comb begin
    err      = ERR_W'(cfg.setpoint) - ERR_W'(s0_meas_q);
    diff     = ERR_W'(s0_meas_q) - ERR_W'(prev_meas_q);
    prod_p_d = PROD_W'(cfg.gain_p) * PROD_W'(err);
    prod_i_d = PROD_W'(cfg.gain_i) * PROD_W'(err);
    prod_d_d = PROD_W'(cfg.gain_d) * PROD_W'(diff);
  end

  // Stage 2: integral update with clamp; the upper limit is applied first so the
  // lower limit wins when the limits are inverted.
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] lim_lo;
  logic signed [SUM_W-1:0] lim_hi;
  logic signed [SUM_W-1:0] acc_hi;
  logic signed [SUM_W-1:0] acc_clamp;
  logic signed [ACC_W-1:0] integral_d;
  logic signed [SUM_W-1:0] pd_d;

  always_comb begin
    acc_sum    = SUM_W'(integral_q) + SUM_W'(s1_prod_i_q);
    lim_lo     = SUM_W'(cfg.min_out) <<< SCALE_SHIFT;
    lim_hi     = SUM_W'(cfg.max_out) <<< SCALE_SHIFT;
    acc_hi     = (acc_sum > lim_hi) ? lim_hi : acc_sum;
    acc_clamp  = (acc_hi < lim_lo) ? lim_lo : acc_hi;
    integral_d = ACC_W'(acc_clamp);
    pd_d       = SUM_W'(s1_prod_p_q) - SUM_W'(s1_prod_d_q);
  end

  // Stage 3: total, divide toward zero by biasing negative values, output clamp.
  logic signed [TOT_W-1:0] tot;
  logic signed [TOT_W-1:0] tot_adj;
  logic signed [TOT_W-1:0] quo;
  logic signed [TOT_W-1:0] quo_hi;
  logic signed [TOT_W-1:0] quo_clamp;
  data_t                   drive_d;

  always_comb begin
    tot       = TOT_W'(s2_pd_q) + TOT_W'(integral_q);
    tot_adj   = tot + (tot[TOT_W-1] ? $signed(ROUND_MASK) : TOT_W'(0));
    quo       = tot_adj >>> SCALE_SHIFT;
    quo_hi    = (quo > TOT_W'(cfg.max_out)) ? TOT_W'(cfg.max_out) : quo;
    quo_clamp = (quo_hi < TOT_W'(cfg.min_out)) ? TOT_W'(cfg.min_out) : quo_hi;
    drive_d   = DATA_W'(quo_clamp);
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_meas_q <= '0;
      integral_q  <= '0;
    end else begin
      if (s0_free) begin
        s0_valid_q <= meas_i.valid;
      end
      if (s1_free) begin
        s1_valid_q <= s0_valid_q;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
      if (s1_load) begin
        prev_meas_q <= s0_meas_q;
      end
      if (s2_load) begin
        integral_q <= integral_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s0_load) begin
      s0_meas_q <= meas_i.measurement;
    end
    if (s1_load) begin
      s1_prod_p_q <= prod_p_d;
      s1_prod_i_q <= prod_i_d;
      s1_prod_d_q <= prod_d_d;
    end
    if (s2_load) begin
      s2_pd_q <= pd_d;
    end
    if (out_load) begin
      out_drive_q <= drive_d;
    end
  end

  // Range checks; the user must hold the limits still while an item is in flight, as the block does not enforce it.
  logic lim_ordered;
  logic integ_ok;
  logic drive_ok;

  assign lim_ordered = (cfg.min_out <= cfg.max_out);
  assign integ_ok    = (SUM_W'(integral_q) >= lim_lo) && (SUM_W'(integral_q) <= lim_hi);
  assign drive_ok    = (out_drive_q >= cfg.min_out) && (out_drive_q <= cfg.max_out);

  // With ordered limits the stored integral stays inside the scaled limits.
  `PCC_ASSERT_NEXT(a_integral_in_limits, s2_load && lim_ordered, integ_ok)

  // With ordered limits a freshly loaded drive value lies inside them.
  `PCC_ASSERT_NEXT(a_drive_in_limits, out_load && lim_ordered, drive_ok)

  // A drive request only appears after an item sat in the integral stage.
  `PCC_ASSERT_IMPL(a_out_from_s2, $rose(out_valid_q), $past(s2_valid_q))

endmodule
